FILE: hdl/assert_macros.svh
// Assertion macros for the checker file of the factorizer.
// Each macro takes a label, a clock, a reset and the terms of one property.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/tdf_pkg.sv
// Package for the trial division factorizer: widths, payload types and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package tdf_pkg;

  localparam int VALUE_WIDTH   = 31;
  localparam int MAX_RESULTS   = 31;
  localparam int CNT_WIDTH     = $clog2(MAX_RESULTS + 1);
  localparam int DIV_CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

  typedef logic [VALUE_WIDTH-1:0]   value_t;
  typedef logic [2*VALUE_WIDTH-1:0] prod_t;
  typedef logic [CNT_WIDTH-1:0]     count_t;
  typedef logic [DIV_CNT_WIDTH-1:0] div_count_t;

  typedef struct packed {
    logic load;
    logic square;
    logic div_start;
    logic incr;
    logic emit_hit;
    logic emit_prime;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic rem_gt1;
    logic sq_gt;
    logic rem_ge;
    logic div_done;
    logic div_zero;
    logic out_free;
  } status_t;

endpackage

FILE: hdl/tdf_if.sv
// Stream interfaces of the factorizer: the request channel and the factor channel.
// Depends on tdf_pkg for the payload types.
`timescale 1ns / 1ps

interface tdf_in_if;
  logic           valid;
  logic           ready;
  tdf_pkg::value_t value;
  tdf_pkg::value_t start_divisor;
  modport source(output valid, output value, output start_divisor, input ready);
  modport sink(input valid, input value, input start_divisor, output ready);
endinterface

interface tdf_out_if;
  logic            valid;
  logic            ready;
  tdf_pkg::value_t factor;
  logic            last;
  modport source(output valid, output factor, output last, input ready);
  modport sink(input valid, input factor, input last, output ready);
endinterface

FILE: hdl/tdf_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tdf_pkg for widths.
`timescale 1ns / 1ps

module tdf_divider (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  tdf_pkg::value_t dividend,
  input  tdf_pkg::value_t divisor,
  output logic            done,
  output tdf_pkg::value_t quotient,
  output logic            rem_zero
);

  tdf_pkg::value_t              rem;
  tdf_pkg::value_t              den;
  tdf_pkg::div_count_t          cnt;
  logic                         busy;
  logic [tdf_pkg::VALUE_WIDTH:0] shifted;
  logic [tdf_pkg::VALUE_WIDTH:0] diff;

  assign shifted  = {rem, quotient[tdf_pkg::VALUE_WIDTH-1]};
  assign diff     = shifted - {1'b0, den};
  assign rem_zero = (rem == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= tdf_pkg::div_count_t'(tdf_pkg::VALUE_WIDTH);
      end else if (busy) begin
        cnt <= cnt - tdf_pkg::div_count_t'(1);
        if (cnt == tdf_pkg::div_count_t'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      den      <= divisor;
    end else if (busy) begin
      if (!diff[tdf_pkg::VALUE_WIDTH]) begin
        rem      <= diff[tdf_pkg::VALUE_WIDTH-1:0];
        quotient <= {quotient[tdf_pkg::VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem      <= shifted[tdf_pkg::VALUE_WIDTH-1:0];
        quotient <= {quotient[tdf_pkg::VALUE_WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: hdl/tdf_datapath.sv
// Datapath of the factorizer: remaining value, trial divisor, square register,
// divider and the output register. Depends on tdf_pkg, tdf_if and tdf_divider.
`timescale 1ns / 1ps

module tdf_datapath (
  input  logic              clk,
  input  logic              rst,
  input  tdf_pkg::value_t   value,
  input  tdf_pkg::value_t   start_divisor,
  input  tdf_pkg::cmd_t     cmd,
  output tdf_pkg::status_t  status,
  tdf_out_if.source         factors
);

  tdf_pkg::value_t remaining;
  tdf_pkg::value_t trial;
  tdf_pkg::prod_t  sq;
  tdf_pkg::value_t quotient;
  logic            div_done;
  logic            div_zero;

  tdf_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (remaining),
    .divisor  (trial),
    .done     (div_done),
    .quotient (quotient),
    .rem_zero (div_zero)
  );

  always_comb begin
    status.rem_gt1  = (remaining > tdf_pkg::value_t'(1));
    status.sq_gt    = (sq > tdf_pkg::prod_t'(remaining));
    status.rem_ge   = (remaining >= trial);
    status.div_done = div_done;
    status.div_zero = div_zero;
    status.out_free = !factors.valid || factors.ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      remaining <= value;
      trial     <= (start_divisor < tdf_pkg::value_t'(2)) ?
                   tdf_pkg::value_t'(2) : start_divisor;
    end else if (cmd.incr) begin
      trial <= trial + tdf_pkg::value_t'(1);
    end else if (cmd.emit_hit) begin
      remaining <= quotient;
    end else if (cmd.emit_prime) begin
      trial     <= remaining;
      remaining <= tdf_pkg::value_t'(1);
    end
    if (cmd.square) begin
      sq <= tdf_pkg::prod_t'(trial) * tdf_pkg::prod_t'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      factors.valid <= 1'b0;
    end else if (cmd.emit_hit || cmd.emit_prime) begin
      factors.valid <= 1'b1;
    end else if (factors.ready) begin
      factors.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_hit) begin
      factors.factor <= trial;
      factors.last   <= cmd.last;
    end else if (cmd.emit_prime) begin
      factors.factor <= remaining;
      factors.last   <= 1'b1;
    end
  end

endmodule

FILE: hdl/tdf_ctrl.sv
// Controller of the factorizer: sequences square, test, divide and emit steps
// and counts the factors of an item. Depends on tdf_pkg.
`timescale 1ns / 1ps

module tdf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tdf_pkg::status_t status,
  output tdf_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {IDLE, SQUARE, TEST, DIVIDE, HIT, PRIME} state_t;

  state_t          state;
  state_t          state_next;
  tdf_pkg::count_t count;
  logic            at_cap;

  assign at_cap = (count == tdf_pkg::count_t'(tdf_pkg::MAX_RESULTS));

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = SQUARE;
        end
      end
      SQUARE: begin
        if (!status.rem_gt1 || at_cap) begin
          state_next = IDLE;
        end else begin
          cmd.square = 1'b1;
          state_next = TEST;
        end
      end
      TEST: begin
        if (status.sq_gt) begin
          state_next = status.rem_ge ? PRIME : IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = DIVIDE;
        end
      end
      DIVIDE: begin
        if (status.div_done) begin
          if (status.div_zero) begin
            state_next = HIT;
          end else begin
            cmd.incr   = 1'b1;
            state_next = SQUARE;
          end
        end
      end
      HIT: begin
        if (status.out_free) begin
          cmd.emit_hit = 1'b1;
          cmd.last     = (count == tdf_pkg::count_t'(tdf_pkg::MAX_RESULTS - 1));
          state_next   = SQUARE;
        end
      end
      PRIME: begin
        if (status.out_free) begin
          cmd.emit_prime = 1'b1;
          state_next     = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        count <= '0;
      end else if (cmd.emit_hit) begin
        count <= count + tdf_pkg::count_t'(1);
      end
    end
  end

endmodule

FILE: hdl/trial_division_factorizer_top.sv
// Top level of the trial division factorizer.
// Depends on tdf_pkg, tdf_if, tdf_ctrl and tdf_datapath.
//
// Each request item carries a value and a start divisor (below 2 means 2); the
// block returns the factors found by trial division from the start divisor up
// (the prime factors when it is 2) in ascending order, one item each, the final
// one flagged last, at most 31 per request; a value of 0 or 1 gives none. One
// request is worked at a time. Each trial divisor passes a square, a compare
// and the one-bit-per-cycle restoring divider, a hit adds an emit step that
// waits for a free output register, and the search stops once the square of
// the divisor exceeds the remaining value. The final factor waits in the output
// register while the next request is taken.
`timescale 1ns / 1ps

module trial_division_factorizer_top (
  input logic clk,
  input logic rst,
  tdf_in_if.sink    request,
  tdf_out_if.source factors
);

  tdf_pkg::cmd_t    cmd;
  tdf_pkg::status_t status;

  tdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (request.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tdf_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .value         (request.value),
    .start_divisor (request.start_divisor),
    .cmd           (cmd),
    .status        (status),
    .factors       (factors)
  );

endmodule

FILE: hdl/tdf_checker.sv
// Port-level checks of the factorizer, bound to the top level.
// Depends on tdf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tdf_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input tdf_pkg::value_t factor,
  input logic            last
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(factor) && $stable(last))
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_SAME(a_factor_min, clk, rst, out_valid, factor > tdf_pkg::value_t'(1))
  `ASSERT_SAME(a_no_accept_midway, clk, rst, out_valid && !last, !in_ready)

endmodule

bind trial_division_factorizer_top tdf_checker u_tdf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (request.valid),
  .in_ready  (request.ready),
  .out_valid (factors.valid),
  .out_ready (factors.ready),
  .factor    (factors.factor),
  .last      (factors.last)
);
